>>> sv/text_console_writer_macros.svh
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console writer check failed");

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console writer check failed");

`endif

>>> sv/tcw_pkg.sv
// Types and constants for the text console writer.
package tcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_ROWCLR,
    ST_EMIT
  } state_t;

  localparam logic [7:0]  NEWLINE_CODE  = 8'h0a;
  localparam logic [7:0]  SPACE_CODE    = 8'h20;
  localparam logic [7:0]  ATTR_RESET    = 8'h07;
  localparam logic [15:0] CELL_RESET    = 16'h0720;
  localparam logic [15:0] CELL_BLANK    = 16'h0000;
  localparam int unsigned POS_W         = 11;
  localparam int unsigned CELL_W        = 16;

endpackage

>>> sv/text_console_writer.sv
// Text console writer: cell store in one RAM, scrolling by a moving row base.
// A put, a newline, an out-of-range read or an unused command goes straight to the result
// register; a read passes through ST_READ, a scroll through a row clear, a clear through a fill.
// One item at a time, and the next word is accepted while the previous result waits.
// A clear sweeps one cell a cycle.
// Reset (rst, synchronous) starts a pass over all ROWS*COLUMNS cells writing 0x0720.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // attribute
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,       // command[1:0], char_code[9:2], cell_index[20:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // cursor_pos[10:0], cell_value[26:11], scrolled[27]
);

  `include "text_console_writer_macros.svh"

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned XW    = ((AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W) + 1;

  // input word fields
  tcw_pkg::cmd_t                 in_cmd;
  logic [7:0]                    in_char;
  logic [tcw_pkg::POS_W-1:0]     in_index;

  assign in_cmd   = tcw_pkg::cmd_t'(s_tdata[1:0]);
  assign in_char  = s_tdata[9:2];
  assign in_index = s_tdata[20:10];

  // control state
  tcw_pkg::state_t state, state_next;
  logic [7:0]      attribute;
  logic [AW-1:0]   sweep_addr, sweep_addr_next;
  logic [AW-1:0]   sweep_last, sweep_last_next;
  logic [15:0]     fill_value, fill_value_next;
  logic [CW-1:0]   col, col_next;
  logic [RW-1:0]   row, row_next;
  logic [AW-1:0]   row_start, row_start_next;    // logical start of cursor row
  logic [AW-1:0]   prow_start, prow_start_next;  // physical start of cursor row
  logic [AW-1:0]   base, base_next;              // physical start of top row
  logic            res_scrolled, res_scrolled_next;
  logic            res_read, res_read_next;
  logic            m_tvalid_next;

  // result word
  logic [tcw_pkg::POS_W-1:0]  out_cursor, out_cursor_next;
  logic [tcw_pkg::CELL_W-1:0] out_cell, out_cell_next;
  logic                       out_scrolled, out_scrolled_next;

  // cell store
  logic [15:0]   screen [CELLS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_q;

  // address arithmetic
  logic [AW:0]    base_adv, prow_adv, rd_sum;
  logic [AW-1:0]  base_wrap, prow_wrap, rd_addr;
  logic [XW-1:0]  idx_x;
  logic           idx_ok;
  logic [AW-1:0]  cursor_lin;
  logic           accept, out_load, last_col, last_row;

  assign s_tready = (state == tcw_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {4'b0, out_scrolled, out_cell, out_cursor};

  assign base_adv  = {1'b0, base} + (AW+1)'(COLUMNS);
  assign base_wrap = (base_adv == (AW+1)'(CELLS)) ? '0 : base_adv[AW-1:0];
  assign prow_adv  = {1'b0, prow_start} + (AW+1)'(COLUMNS);
  assign prow_wrap = (prow_adv == (AW+1)'(CELLS)) ? '0 : prow_adv[AW-1:0];

  assign idx_x   = XW'(in_index);
  assign idx_ok  = idx_x < XW'(CELLS);
  assign rd_sum  = {1'b0, AW'(in_index)} + {1'b0, base};
  assign rd_addr = (rd_sum >= (AW+1)'(CELLS)) ? AW'(rd_sum - (AW+1)'(CELLS))
                                             : rd_sum[AW-1:0];

  assign cursor_lin = row_start + AW'(col);
  assign last_col   = (col == CW'(COLUMNS - 1));
  assign last_row   = (row == RW'(ROWS - 1));
  assign out_load   = (state == tcw_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next        = state;
    sweep_addr_next   = sweep_addr;
    sweep_last_next   = sweep_last;
    fill_value_next   = fill_value;
    col_next          = col;
    row_next          = row;
    row_start_next    = row_start;
    prow_start_next   = prow_start;
    base_next         = base;
    res_scrolled_next = res_scrolled;
    res_read_next     = res_read;
    mem_we            = 1'b0;
    mem_waddr         = sweep_addr;
    mem_wdata         = fill_value;
    mem_re            = 1'b0;
    mem_raddr         = rd_addr;

    unique case (state) inside
      tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
        mem_we          = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == AW'(CELLS - 1)) begin
          state_next = (state == tcw_pkg::ST_INIT) ? tcw_pkg::ST_IDLE : tcw_pkg::ST_EMIT;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          res_scrolled_next = 1'b0;
          res_read_next     = 1'b0;
          state_next        = tcw_pkg::ST_EMIT;
          unique case (in_cmd)
            tcw_pkg::CMD_PUT: begin
              if (in_char != tcw_pkg::NEWLINE_CODE) begin
                mem_we    = 1'b1;
                mem_waddr = prow_start + AW'(col);
                mem_wdata = {attribute, in_char};
              end
              if (in_char == tcw_pkg::NEWLINE_CODE || last_col) begin
                col_next = '0;
                if (last_row) begin
                  // new bottom row is the old top row; clear it in place
                  base_next         = base_wrap;
                  prow_start_next   = base;
                  sweep_addr_next   = base;
                  sweep_last_next   = base + AW'(COLUMNS - 1);
                  res_scrolled_next = 1'b1;
                  state_next        = tcw_pkg::ST_ROWCLR;
                end else begin
                  row_next        = row + 1'b1;
                  row_start_next  = row_start + AW'(COLUMNS);
                  prow_start_next = prow_wrap;
                end
              end else begin
                col_next = col + 1'b1;
              end
            end
            tcw_pkg::CMD_READ: begin
              if (idx_ok) begin
                mem_re        = 1'b1;
                res_read_next = 1'b1;
                state_next    = tcw_pkg::ST_READ;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              fill_value_next = {attribute, tcw_pkg::SPACE_CODE};
              sweep_addr_next = '0;
              col_next        = '0;
              row_next        = '0;
              row_start_next  = '0;
              prow_start_next = '0;
              base_next       = '0;
              state_next      = tcw_pkg::ST_FILL;
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        state_next = tcw_pkg::ST_EMIT;
      end
      tcw_pkg::ST_ROWCLR: begin
        mem_we          = 1'b1;
        mem_wdata       = tcw_pkg::CELL_BLANK;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == sweep_last) begin
          state_next = tcw_pkg::ST_EMIT;
        end
      end
      tcw_pkg::ST_EMIT: begin
        if (out_load) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  assign m_tvalid_next     = out_load || (m_tvalid && !m_tready);
  assign out_cursor_next   = out_load ? tcw_pkg::POS_W'(cursor_lin) : out_cursor;
  assign out_cell_next     = out_load ? (res_read ? mem_q : '0) : out_cell;
  assign out_scrolled_next = out_load ? res_scrolled : out_scrolled;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tcw_pkg::ST_INIT;
      sweep_addr   <= '0;
      fill_value   <= tcw_pkg::CELL_RESET;
      col          <= '0;
      row          <= '0;
      row_start    <= '0;
      prow_start   <= '0;
      base         <= '0;
      res_scrolled <= 1'b0;
      res_read     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      sweep_addr   <= sweep_addr_next;
      fill_value   <= fill_value_next;
      col          <= col_next;
      row          <= row_next;
      row_start    <= row_start_next;
      prow_start   <= prow_start_next;
      base         <= base_next;
      res_scrolled <= res_scrolled_next;
      res_read     <= res_read_next;
      m_tvalid     <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      attribute <= cfg_wr_data;
    end
  end

  // payload holds
  always_ff @(posedge clk) begin
    sweep_last   <= sweep_last_next;
    out_cursor   <= out_cursor_next;
    out_cell     <= out_cell_next;
    out_scrolled <= out_scrolled_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= screen[mem_raddr];
    end
  end

  `TCW_ASSERT_NOW(a_column_in_range, 1'b1, {1'b0, col} < (CW+1)'(COLUMNS))
  `TCW_ASSERT_NOW(a_row_in_range, 1'b1, {1'b0, row} < (RW+1)'(ROWS))
  `TCW_ASSERT_NOW(a_base_in_range, 1'b1, {1'b0, base} < (AW+1)'(CELLS))
  `TCW_ASSERT_NOW(a_scroll_on_last_row, out_load && res_scrolled, last_row)
  `TCW_ASSERT_NOW(a_idle_write_is_put, mem_we && s_tready, accept && (in_cmd == tcw_pkg::CMD_PUT))
  `TCW_ASSERT_NEXT(a_result_drains, m_tvalid && m_tready && !out_load, !m_tvalid)

endmodule
